// ----- hw/rtl/scbsa_pkg.sv -----
// ----------------------------------------------------------------------------
// scbsa_pkg: shared definitions of the size-class slot allocator
// Field widths, operation and status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package scbsa_pkg;

  // Default geometry of the free bitmap
  localparam int MAX_CLASSES_DEF     = 8;
  localparam int SLOTS_PER_CLASS_DEF = 512;
  localparam int MAP_WORD_BITS_DEF   = 64;

  // Slot count of a class: (classes - class) * SLOT_GROUP, rounded up to SLOT_ROUND
  localparam int SLOT_GROUP = 60;
  localparam int SLOT_ROUND = 8;

  // Transaction field widths
  localparam int BYTES_W     = 32;
  localparam int ALIGN_W     = 16;
  localparam int SLOT_IO_W   = 9;
  localparam int STATUS_W    = 3;
  localparam int CLASS_IO_W  = 3;
  localparam int GRANT_W     = 32;
  localparam int LOG2_W      = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CLASS_LOG2 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLASS_LOG2 = CFG_INDEX_W'(1);

  // Register reset values
  localparam logic [LOG2_W-1:0] MIN_CLASS_LOG2_RST = LOG2_W'(3);
  localparam logic [LOG2_W-1:0] MAX_CLASS_LOG2_RST = LOG2_W'(10);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TOO_BIG    = 3'd1,
    ST_BAD_ALIGN  = 3'd2,
    ST_CLASS_FULL = 3'd3,
    ST_SLOT_RANGE = 3'd4
  } status_t;

endpackage

// ----- hw/rtl/scbsa_req_if.sv -----
// ----------------------------------------------------------------------------
// scbsa_req_if: request channel
// Allocate or free requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scbsa_req_if;
  import scbsa_pkg::*;

  logic                 valid;
  logic                 ready;
  op_t                  operation;
  logic [BYTES_W-1:0]   request_bytes;
  logic [ALIGN_W-1:0]   alignment;
  logic [SLOT_IO_W-1:0] slot_to_free;

  modport source (output valid, operation, request_bytes, alignment, slot_to_free,
                  input ready);
  modport sink   (input valid, operation, request_bytes, alignment, slot_to_free,
                  output ready);
endinterface

// ----- hw/rtl/scbsa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// scbsa_rsp_if: result channel
// One result per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scbsa_rsp_if;
  import scbsa_pkg::*;

  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [CLASS_IO_W-1:0] class_index;
  logic [SLOT_IO_W-1:0]  slot_index;
  logic [GRANT_W-1:0]    granted_bytes;

  modport source (output valid, status, class_index, slot_index, granted_bytes,
                  input ready);
  modport sink   (input valid, status, class_index, slot_index, granted_bytes,
                  output ready);
endinterface

// ----- hw/rtl/scbsa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// scbsa_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scbsa_cfg_if;
  import scbsa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/size_class_bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// size_class_bitmap_slot_allocator: power-of-two pool allocator
// Picks a size class from the request, grants the lowest free slot from that
// class's free bitmap, or returns a slot to it.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  in_chan   in   valid/ready    operation, request_bytes, alignment, slot_to_free
//  out_chan  out  valid/ready    status, class_index, slot_index, granted_bytes
//  cfg_chan  in   valid/ready    index, data (min/max class log2)
//
//  Allocate: class decode, then a scan of the class's bitmap words (1 .. words
//  per class, 8 by default), the bitmap RAM giving one word per cycle, then the
//  result state. Free: class decode, word seek, read, write back, result state.
//  A rejected request goes from the class decode straight to the result state.
//  After reset a clearing pass writes every bitmap word to all ones, one word
//  a cycle (MAX_CLASSES * words per class words, 64 by default); no request is
//  taken meanwhile, configuration writes are. A stalled result waits in the
//  output register while the next request is taken.
//
module size_class_bitmap_slot_allocator #(
  parameter int MAX_CLASSES     = scbsa_pkg::MAX_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = scbsa_pkg::SLOTS_PER_CLASS_DEF,
  parameter int MAP_WORD_BITS   = scbsa_pkg::MAP_WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  scbsa_req_if.sink    in_chan,
  scbsa_rsp_if.source  out_chan,
  scbsa_cfg_if.sink    cfg_chan
);
  import scbsa_pkg::*;

  localparam int WPC       = (SLOTS_PER_CLASS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MAP_WORDS = MAX_CLASSES * WPC;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CLS_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CCNT_W    = $clog2(MAX_CLASSES + 1);
  localparam int CNT_W     = $clog2(SLOTS_PER_CLASS + 1);
  localparam int SLOT_W    = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int RAW_W     = $clog2(MAX_CLASSES * SLOT_GROUP + SLOT_ROUND) + 1;
  localparam int NUM_W     = ((RAW_W > CNT_W) ? RAW_W : CNT_W) + 1;
  localparam int BIT_W     = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
  localparam int CMP_W     = ((CNT_W > SLOT_IO_W) ? CNT_W : SLOT_IO_W) + 1;
  localparam int SIZE_W    = BYTES_W + 1;
  localparam int EXP_W     = LOG2_W + 1;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_CLASS   = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_SEEK    = 7'b0010000,
    S_FREE_WR = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  // Control registers
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [LOG2_W-1:0]   min_r, max_r;
  logic                out_valid_r, out_valid_nxt;

  // Datapath registers
  op_t                 op_r, op_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic                align_bad_r, align_bad_nxt;
  logic [SLOT_IO_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]    nslots_r, nslots_nxt;
  logic [EXP_W-1:0]    k_r, k_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    sbase_r, sbase_nxt;
  logic [BIT_W-1:0]    off_r, off_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [CLS_W-1:0]    res_cls_r, res_cls_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [GRANT_W-1:0]  res_grant_r, res_grant_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [CLS_W-1:0]    out_cls_r, out_cls_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [GRANT_W-1:0]  out_grant_r, out_grant_nxt;

  // RAM port
  logic                     ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]        ram_wr_addr, ram_rd_addr;
  logic [MAP_WORD_BITS-1:0] ram_wr_data, ram_rd_data;

  // Request decode
  logic [ALIGN_W-1:0]  align_m1;
  logic                align_bad;
  logic [SIZE_W-1:0]   size_alloc;

  // Class decode
  logic [SIZE_W-1:0]      size_m1, size_sh;
  logic [MAX_CLASSES-1:0] fits_class, class_mask;
  logic [EXP_W-1:0]       span;
  logic [CCNT_W-1:0]      classes;
  logic                   fits;
  logic [CLS_W-1:0]       cls;
  logic [NUM_W-1:0]       raw_slots, rnd_slots;
  logic [CNT_W-1:0]       nslots;
  logic [ADDR_W-1:0]      base;
  logic                   slot_bad;

  // Word scan
  logic [CNT_W-1:0]         rem;
  logic [MAP_WORD_BITS-1:0] vmask, avail, lowest;
  logic [BIT_W-1:0]         bidx;
  logic                     last_word, seek_hit;
  logic                     out_load;

  scbsa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  // Round the request up to the alignment
  always_comb begin
    align_m1   = in_chan.alignment - ALIGN_W'(1);
    align_bad  = (in_chan.alignment == '0) || ((in_chan.alignment & align_m1) != '0);
    size_alloc = (SIZE_W'(in_chan.request_bytes) + SIZE_W'(align_m1)) & ~SIZE_W'(align_m1);
  end

  // Find the size class: size <= 2^(min + c) for the lowest c
  always_comb begin
    size_m1 = (size_r == '0) ? '0 : size_r - SIZE_W'(1);
    size_sh = size_m1 >> min_r;
    for (int c = 0; c < MAX_CLASSES; c++) begin
      fits_class[c] = ((size_sh >> c) == '0);
      class_mask[c] = (CCNT_W'(c) < classes);
    end
    span = EXP_W'(max_r) - EXP_W'(min_r) + EXP_W'(1);
    if (max_r < min_r) begin
      classes = '0;
    end else if (span > EXP_W'(MAX_CLASSES)) begin
      classes = CCNT_W'(MAX_CLASSES);
    end else begin
      classes = CCNT_W'(span);
    end
    fits = (classes != '0) && fits_class[CLS_W'(classes - CCNT_W'(1))];
    cls  = CLS_W'($countones(~fits_class & class_mask));
    raw_slots = (NUM_W'(classes) - NUM_W'(cls)) * NUM_W'(SLOT_GROUP);
    rnd_slots = (raw_slots + NUM_W'(SLOT_ROUND - 1)) & ~NUM_W'(SLOT_ROUND - 1);
    nslots = (rnd_slots > NUM_W'(SLOTS_PER_CLASS)) ? CNT_W'(SLOTS_PER_CLASS)
                                                   : CNT_W'(rnd_slots);
    base     = ADDR_W'(int'(cls) * WPC);
    slot_bad = (CMP_W'(slot_r) >= CMP_W'(nslots));
  end

  // Lowest free slot of the current word, limited to the class's slot count
  always_comb begin
    rem = nslots_r - sbase_r;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      vmask[b] = (CNT_W'(b) < rem);
    end
    avail  = ram_rd_data & vmask;
    lowest = avail & (~avail + MAP_WORD_BITS'(1));
    bidx   = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (lowest[b]) begin
        bidx = bidx | BIT_W'(b);
      end
    end
    last_word = ((CNT_W + 1)'(sbase_r) + (CNT_W + 1)'(MAP_WORD_BITS))
                >= (CNT_W + 1)'(nslots_r);
    seek_hit  = CMP_W'(slot_r) < (CMP_W'(sbase_r) + CMP_W'(MAP_WORD_BITS));
  end

  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_chan.ready);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    size_nxt       = size_r;
    align_bad_nxt  = align_bad_r;
    slot_nxt       = slot_r;
    nslots_nxt     = nslots_r;
    k_nxt          = k_r;
    addr_nxt       = addr_r;
    sbase_nxt      = sbase_r;
    off_nxt        = off_r;
    res_status_nxt = res_status_r;
    res_cls_nxt    = res_cls_r;
    res_slot_nxt   = res_slot_r;
    res_grant_nxt  = res_grant_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = addr_r;
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = addr_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        ram_wr_data = '1;
        clr_nxt     = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt        = in_chan.operation;
          size_nxt      = (in_chan.operation == OP_ALLOC) ? size_alloc
                                                          : SIZE_W'(in_chan.request_bytes);
          align_bad_nxt = align_bad;
          slot_nxt      = in_chan.slot_to_free;
          state_nxt     = S_CLASS;
        end
      end

      S_CLASS: begin
        res_slot_nxt  = '0;
        res_grant_nxt = '0;
        res_cls_nxt   = '0;
        nslots_nxt    = nslots;
        k_nxt         = EXP_W'(min_r) + EXP_W'(cls);
        sbase_nxt     = '0;
        addr_nxt      = base;
        if (align_bad_r) begin
          res_status_nxt = ST_BAD_ALIGN;
          state_nxt      = S_RESP;
        end else if (!fits) begin
          res_status_nxt = ST_TOO_BIG;
          state_nxt      = S_RESP;
        end else if (op_r == OP_ALLOC) begin
          // Issue the class's first word
          ram_rd_en   = 1'b1;
          ram_rd_addr = base;
          res_cls_nxt = cls;
          state_nxt   = S_SCAN;
        end else if (slot_bad) begin
          res_status_nxt = ST_SLOT_RANGE;
          res_cls_nxt    = cls;
          state_nxt      = S_RESP;
        end else begin
          res_cls_nxt = cls;
          state_nxt   = S_SEEK;
        end
      end

      S_SCAN: begin
        if (avail != '0) begin
          // Claim the slot and write the word back
          ram_wr_en      = 1'b1;
          ram_wr_addr    = addr_r;
          ram_wr_data    = ram_rd_data & ~lowest;
          res_status_nxt = ST_OK;
          res_slot_nxt   = SLOT_W'(sbase_r + CNT_W'(bidx));
          res_grant_nxt  = GRANT_W'(1) << k_r;
          state_nxt      = S_RESP;
        end else if (last_word) begin
          res_status_nxt = ST_CLASS_FULL;
          state_nxt      = S_RESP;
        end else begin
          // Advance to the next word, read one ahead
          ram_rd_en   = 1'b1;
          ram_rd_addr = addr_r + ADDR_W'(1);
          addr_nxt    = addr_r + ADDR_W'(1);
          sbase_nxt   = sbase_r + CNT_W'(MAP_WORD_BITS);
        end
      end

      S_SEEK: begin
        if (seek_hit) begin
          ram_rd_en = 1'b1;
          off_nxt   = BIT_W'(CMP_W'(slot_r) - CMP_W'(sbase_r));
          state_nxt = S_FREE_WR;
        end else begin
          addr_nxt  = addr_r + ADDR_W'(1);
          sbase_nxt = sbase_r + CNT_W'(MAP_WORD_BITS);
        end
      end

      S_FREE_WR: begin
        ram_wr_en      = 1'b1;
        ram_wr_data    = ram_rd_data | (MAP_WORD_BITS'(1) << off_r);
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_cls_nxt    = out_cls_r;
    out_slot_nxt   = out_slot_r;
    out_grant_nxt  = out_grant_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_cls_nxt    = res_cls_r;
      out_slot_nxt   = res_slot_r;
      out_grant_nxt  = res_grant_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.class_index   = CLASS_IO_W'(out_cls_r);
  assign out_chan.slot_index    = SLOT_IO_W'(out_slot_r);
  assign out_chan.granted_bytes = out_grant_r;

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      min_r       <= MIN_CLASS_LOG2_RST;
      max_r       <= MAX_CLASS_LOG2_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_MIN_CLASS_LOG2: min_r <= cfg_chan.data[LOG2_W-1:0];
          REG_MAX_CLASS_LOG2: max_r <= cfg_chan.data[LOG2_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    size_r       <= size_nxt;
    align_bad_r  <= align_bad_nxt;
    slot_r       <= slot_nxt;
    nslots_r     <= nslots_nxt;
    k_r          <= k_nxt;
    addr_r       <= addr_nxt;
    sbase_r      <= sbase_nxt;
    off_r        <= off_nxt;
    res_status_r <= res_status_nxt;
    res_cls_r    <= res_cls_nxt;
    res_slot_r   <= res_slot_nxt;
    res_grant_r  <= res_grant_nxt;
    out_status_r <= out_status_nxt;
    out_cls_r    <= out_cls_nxt;
    out_slot_r   <= out_slot_nxt;
    out_grant_r  <= out_grant_nxt;
  end

endmodule

// ----- hw/rtl/scbsa_ram.sv -----
// ----------------------------------------------------------------------------
// scbsa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scbsa_ram #(
  parameter int  WIDTH = scbsa_pkg::MAP_WORD_BITS_DEF,
  parameter int  DEPTH = scbsa_pkg::MAX_CLASSES_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
